FILE: design/pidq_pkg.sv
// Shared types and constants for the process-id deque.
`default_nettype none

package pidq_pkg;

    // Field widths of the item formats
    localparam int PID_W    = 8;
    localparam int CMD_W    = 3;
    localparam int STATUS_W = 3;
    localparam int POS_W    = 4;
    localparam int COUNT_W  = 5;

    // Padded stream widths
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 24;

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND    = 3'd0,
        CMD_TAKE_HEAD = 3'd1,
        CMD_TAKE_TAIL = 3'd2,
        CMD_REMOVE    = 3'd3,
        CMD_FIND      = 3'd4
    } cmd_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_FULL     = 3'd2,
        ST_BAD      = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    // Per-cell slot control
    typedef struct packed {
        logic load;   // take the incoming id
        logic shift;  // take the neighbour's id (move towards the head)
    } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: design/pidq_cell.sv
// One slot of the deque: holds an id, compares it, passes the first-match flag on.
`default_nettype none

module pidq_cell
    import pidq_pkg::*;
(
    input  wire logic             aclk,
    input  wire cell_ctrl_t       ctrl,
    input  wire logic [PID_W-1:0] pid,
    input  wire logic [PID_W-1:0] next_slot,  // slot of the neighbour nearer the tail
    input  wire logic             valid,      // slot lies inside the held count
    input  wire logic             found_in,   // a match lies nearer the head
    output logic [PID_W-1:0]      slot,
    output logic                  match,      // valid slot equals pid
    output logic                  hit,        // first match from the head
    output logic                  found_out
);

    logic [PID_W-1:0] slot_reg;

    // Slot storage: load from the command, or shift one place towards the head
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            slot_reg <= pid;
        end else if (ctrl.shift) begin
            slot_reg <= next_slot;
        end
    end

    // Compare and first-match chain
    assign slot      = slot_reg;
    assign match     = valid && (slot_reg == pid);
    assign hit       = match && !found_in;
    assign found_out = found_in || match;

endmodule

`default_nettype wire

FILE: design/process_id_deque_with_removal.sv
// Top level of the process-id deque: a row of slot cells, command decode and result register.
//
// Usage:
//   s_ channel carries one command per item: cmd, pid and pid_alive.
//   m_ channel returns exactly one result item per command: the id appended,
//   taken, removed or found, a status code, the position of a found id, and
//   the count and empty/full flags after the command.
//   Every slot compares its id with the command's id at once and a first-match
//   flag ripples down the row; removal shifts every slot past the match one
//   place towards the head when the command is accepted. The result is
//   registered, so m_tvalid rises in the cycle after acceptance; one item per
//   cycle is sustained while the receiver takes results.
//   The result register is the only buffer: while it holds an untaken result
//   and m_tready is low, s_tready is low and the queue does not change.
//   Reset (aresetn low at a clock edge) empties the queue and drops any
//   waiting result; slot contents are not cleared, as no slot beyond the
//   held count is ever read.
`default_nettype none

module process_id_deque_with_removal
    import pidq_pkg::*;
#(
    parameter int MAX_PROCS = 16
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // s_tdata: cmd[2:0], pid[10:3], pid_alive[11], zero pad
    input  wire logic [S_DATA_W-1:0] s_tdata,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // m_tdata: result_pid[7:0], status[10:8], position[14:11],
    //          entry_count[19:15], is_empty[20], is_full[21], zero pad
    output logic [M_DATA_W-1:0]      m_tdata,
    output logic                     m_tvalid,
    input  wire logic                m_tready
);

    localparam int CW = $clog2(MAX_PROCS + 1);
    localparam logic [CW-1:0]    FULL_COUNT = CW'(MAX_PROCS);
    localparam logic [PID_W:0]   PID_LIMIT  = (PID_W + 1)'(MAX_PROCS);

    // Input fields
    logic [CMD_W-1:0] cmd;
    logic [PID_W-1:0] pid;
    logic             pid_alive;

    assign cmd       = s_tdata[CMD_W-1:0];
    assign pid       = s_tdata[CMD_W +: PID_W];
    assign pid_alive = s_tdata[CMD_W + PID_W];

    // State
    logic [CW-1:0]       count_reg, count_next;
    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic accept;
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // Cell row signals
    cell_ctrl_t       ctrl    [MAX_PROCS];
    logic [PID_W-1:0] slot    [MAX_PROCS];
    logic [MAX_PROCS-1:0] match, hit, last;
    logic [MAX_PROCS:0]   found;
    logic [CW-1:0]        count_dec;

    assign found[0]  = 1'b0;
    assign count_dec = count_reg - CW'(1);

    // Command decode outcome
    logic do_load, do_shift_all, do_shift_hit;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_PROCS; gi++) begin : g_cell
            logic [PID_W-1:0] nbr;
            if (gi == MAX_PROCS - 1) begin : g_end
                assign nbr = slot[gi];
            end else begin : g_mid
                assign nbr = slot[gi+1];
            end

            assign last[gi]       = (CW'(gi) == count_dec);
            assign ctrl[gi].load  = accept && do_load && (CW'(gi) == count_reg);
            assign ctrl[gi].shift = accept && (do_shift_all || (do_shift_hit && found[gi+1]));

            pidq_cell u_cell (
                .aclk      (aclk),
                .ctrl      (ctrl[gi]),
                .pid       (pid),
                .next_slot (nbr),
                .valid     (CW'(gi) < count_reg),
                .found_in  (found[gi]),
                .slot      (slot[gi]),
                .match     (match[gi]),
                .hit       (hit[gi]),
                .found_out (found[gi+1])
            );
        end
    endgenerate

    // Tail value and first-match position, gathered over the row
    logic [PID_W-1:0] tail_val;
    logic [POS_W-1:0] hit_pos;
    logic             tail_match;

    always_comb begin
        tail_val   = '0;
        hit_pos    = '0;
        tail_match = 1'b0;
        for (int i = 0; i < MAX_PROCS; i++) begin
            if (last[i]) begin
                tail_val = tail_val | slot[i];
            end
            if (hit[i]) begin
                hit_pos = hit_pos | POS_W'(i);
            end
            tail_match = tail_match | (match[i] & last[i]);
        end
    end

    // Command decode
    logic             is_empty_now, is_full_now, bad_id, any_hit;
    status_t          status;
    logic [PID_W-1:0] result_pid;
    logic [POS_W-1:0] position;

    assign is_empty_now = (count_reg == '0);
    assign is_full_now  = (count_reg == FULL_COUNT);
    assign bad_id       = ({1'b0, pid} >= PID_LIMIT) || !pid_alive;
    assign any_hit      = found[MAX_PROCS];

    always_comb begin
        status       = ST_OK;
        result_pid   = '0;
        position     = '0;
        count_next   = count_reg;
        do_load      = 1'b0;
        do_shift_all = 1'b0;
        do_shift_hit = 1'b0;
        unique case (cmd)
            CMD_APPEND: begin
                if (is_full_now) begin
                    status = ST_FULL;
                end else if (bad_id) begin
                    status = ST_BAD;
                end else begin
                    do_load    = 1'b1;
                    count_next = count_reg + CW'(1);
                    result_pid = pid;
                end
            end
            CMD_TAKE_HEAD: begin
                if (is_empty_now) begin
                    status = ST_EMPTY;
                end else begin
                    result_pid   = slot[0];
                    do_shift_all = 1'b1;
                    count_next   = count_dec;
                end
            end
            CMD_TAKE_TAIL: begin
                if (is_empty_now) begin
                    status = ST_EMPTY;
                end else begin
                    result_pid = tail_val;
                    count_next = count_dec;
                end
            end
            CMD_REMOVE: begin
                priority if (is_empty_now) begin
                    status = ST_EMPTY;
                end else if (bad_id) begin
                    status = ST_BAD;
                end else if (match[0]) begin
                    result_pid   = pid;
                    do_shift_all = 1'b1;
                    count_next   = count_dec;
                end else if (tail_match) begin
                    result_pid = pid;
                    count_next = count_dec;
                end else if (any_hit) begin
                    result_pid   = pid;
                    do_shift_hit = 1'b1;
                    count_next   = count_dec;
                end else begin
                    status = ST_NOTFOUND;
                end
            end
            CMD_FIND: begin
                priority if (is_empty_now) begin
                    status = ST_EMPTY;
                end else if (bad_id) begin
                    status = ST_BAD;
                end else if (any_hit) begin
                    result_pid = pid;
                    position   = hit_pos;
                end else begin
                    status = ST_NOTFOUND;
                end
            end
            default: begin
                // unused command codes leave the queue as it is
            end
        endcase
    end

    // Result packing
    always_comb begin
        m_tdata_next = '0;
        m_tdata_next[7:0]   = result_pid;
        m_tdata_next[10:8]  = status;
        m_tdata_next[14:11] = position;
        m_tdata_next[19:15] = COUNT_W'(count_next);
        m_tdata_next[20]    = (count_next == '0);
        m_tdata_next[21]    = (count_next == FULL_COUNT);
    end

    // Count and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg    <= count_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire
